### src/rpa_pkg.sv
`default_nettype none

package rpa_pkg;

    // sizes of the page store
    localparam int NUM_PAGES = 32768;
    localparam int REF_WIDTH = 8;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int DEPTH_W   = PAGE_W + 1;

    // widths fixed by the request and response fields
    localparam int PG_FIELD_W  = 15;
    localparam int END_W       = 16;
    localparam int CNT_FIELD_W = 8;

    // apb map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_END   = 1'b1;

    localparam logic [REF_WIDTH-1:0] CNT_MAX = {REF_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INCR  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_RANGE     = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_SATURATED = 3'd3,
        STAT_FREE_ZERO = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [PG_FIELD_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [PG_FIELD_W-1:0]  page_out;
        logic [CNT_FIELD_W-1:0] ref_count;
        logic                   page_released;
    } rsp_t;

    typedef struct packed {
        logic [PG_FIELD_W-1:0] free_first_page;
        logic [END_W-1:0]      free_end_page;
    } cfg_t;

endpackage

`default_nettype wire

### src/rpa_ram.sv
`default_nettype none

module rpa_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/rpa_cfg.sv
`default_nettype none

module rpa_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rpa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rpa_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output rpa_pkg::cfg_t                     cfg
);

    logic [rpa_pkg::PG_FIELD_W-1:0] first_reg;
    logic [rpa_pkg::END_W-1:0]      end_reg;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // word aligned: bit 2 picks the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            end_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                rpa_pkg::REG_FIRST: first_reg <= pwdata[rpa_pkg::PG_FIELD_W-1:0];
                rpa_pkg::REG_END:   end_reg   <= pwdata[rpa_pkg::END_W-1:0];
                default:            first_reg <= first_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rpa_pkg::REG_FIRST: prdata = rpa_pkg::PDATA_W'(first_reg);
            rpa_pkg::REG_END:   prdata = rpa_pkg::PDATA_W'(end_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.free_first_page = first_reg;
    assign cfg.free_end_page   = end_reg;

endmodule

`default_nettype wire

### src/page_allocator_refcount.sv
`default_nettype none

// Physical page allocator with a per-page reference count. Each request is
// one of allocate, free, increment or read and gives exactly one response.
// Allocate pops the stack of released pages first (last released, first
// given), then hands out never-used pages downward from free_end_page-2;
// the last page of the region is never handed out fresh. On acceptance in
// the idle state a request reads the count memory (and the free stack); the
// execute state modifies and writes back, and waits while the response
// register is still held. The next request is taken only after the return
// to idle, so no new request is taken before the last one is through. After
// reset the block clears the count memory one entry per cycle and holds
// req_stall high meanwhile; configuration writes are taken at any time.
module page_allocator_refcount (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire rpa_pkg::req_t                req,
    // response channel
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output rpa_pkg::rsp_t                     rsp,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rpa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rpa_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    localparam int PW = rpa_pkg::PAGE_W;
    localparam int DW = rpa_pkg::DEPTH_W;
    localparam int EW = rpa_pkg::END_W;
    localparam int RW = rpa_pkg::REF_WIDTH;

    rpa_pkg::cfg_t cfg;

    state_t                          state_reg, state_next;
    logic [PW-1:0]                   clr_addr_reg, clr_addr_next;
    rpa_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [rpa_pkg::PG_FIELD_W-1:0]  page_reg, page_next;
    logic [DW-1:0]                   depth_reg, depth_next;
    logic [EW-1:0]                   fresh_reg, fresh_next;
    rpa_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;

    // memory ports
    logic          cnt_we;
    logic [PW-1:0] cnt_wr_addr;
    logic [RW-1:0] cnt_wr_data;
    logic [RW-1:0] cnt_rd_data;
    logic          stk_we;
    logic [PW-1:0] stk_rd_data;

    logic          accept;
    logic          finish;

    // datapath
    logic [EW-1:0]  use_end;
    logic           in_range;
    logic           fresh_ok;
    logic [EW-1:0]  fresh_total;
    logic [EW-1:0]  fresh_page;
    logic           stack_nonempty;
    logic           stack_full;
    logic [PW-1:0]  grant_page;
    logic [RW-1:0]  cnt_dec;
    logic [RW-1:0]  cnt_inc;

    rpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // reference counts, one entry per page
    rpa_ram #(
        .ADDR_W (PW),
        .DATA_W (RW)
    ) u_cnt_ram (
        .clk     (clk),
        .we      (cnt_we),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .re      (accept),
        .rd_addr (PW'(req.page_index)),
        .rd_data (cnt_rd_data)
    );

    // stack of released pages, top entry sits at depth-1
    rpa_ram #(
        .ADDR_W (PW),
        .DATA_W (PW)
    ) u_stk_ram (
        .clk     (clk),
        .we      (stk_we),
        .wr_addr (depth_reg[PW-1:0]),
        .wr_data (PW'(page_reg)),
        .re      (accept),
        .rd_addr (PW'(depth_reg - DW'(1))),
        .rd_data (stk_rd_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    // the response register must be free before a request completes
    assign finish    = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // region bounds, end clamped to the page store
    always_comb
    begin
        use_end = (cfg.free_end_page > EW'(rpa_pkg::NUM_PAGES))
                  ? EW'(rpa_pkg::NUM_PAGES) : cfg.free_end_page;
        in_range = ({1'b0, page_reg} >= EW'(cfg.free_first_page))
                   && ({1'b0, page_reg} < use_end);
        fresh_total = use_end - EW'(1) - EW'(cfg.free_first_page);
        // pool of never-used pages is first .. end-2
        fresh_ok = (({1'b0, use_end}) >= (EW'(cfg.free_first_page) + (EW+1)'(2)))
                   && (fresh_reg < fresh_total);
        fresh_page = use_end - EW'(2) - fresh_reg;
        stack_nonempty = (depth_reg != '0);
        stack_full     = (depth_reg >= DW'(rpa_pkg::NUM_PAGES));
        grant_page = stack_nonempty ? stk_rd_data : PW'(fresh_page);
        cnt_dec = cnt_rd_data - RW'(1);
        cnt_inc = cnt_rd_data + RW'(1);
    end

    // command execution: read data is valid in the execute state
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cnt_we         = 1'b0;
        cnt_wr_addr    = PW'(page_reg);
        cnt_wr_data    = '0;
        stk_we         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we        = 1'b1;
                cnt_wr_addr   = clr_addr_reg;
                cnt_wr_data   = '0;
                clr_addr_next = clr_addr_reg + PW'(1);
                if (clr_addr_reg == {PW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    page_next  = req.page_index;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next.status        = rpa_pkg::STAT_OK;
                    rsp_next.page_out      = page_reg;
                    rsp_next.ref_count     = '0;
                    rsp_next.page_released = 1'b0;
                    case (cmd_reg)
                        rpa_pkg::CMD_ALLOC:
                        begin
                            if (stack_nonempty || fresh_ok)
                            begin
                                if (stack_nonempty)
                                begin
                                    depth_next = depth_reg - DW'(1);
                                end
                                else
                                begin
                                    fresh_next = fresh_reg + EW'(1);
                                end
                                cnt_we      = 1'b1;
                                cnt_wr_addr = grant_page;
                                cnt_wr_data = RW'(1);
                                rsp_next.page_out  = rpa_pkg::PG_FIELD_W'(grant_page);
                                rsp_next.ref_count = rpa_pkg::CNT_FIELD_W'(1);
                            end
                            else
                            begin
                                rsp_next.status   = rpa_pkg::STAT_EMPTY;
                                rsp_next.page_out = '0;
                            end
                        end
                        rpa_pkg::CMD_FREE:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = rpa_pkg::STAT_RANGE;
                            end
                            else if (cnt_rd_data == '0)
                            begin
                                rsp_next.status = rpa_pkg::STAT_FREE_ZERO;
                            end
                            else
                            begin
                                cnt_we      = 1'b1;
                                cnt_wr_data = cnt_dec;
                                rsp_next.ref_count = rpa_pkg::CNT_FIELD_W'(cnt_dec);
                                if (cnt_dec == '0)
                                begin
                                    rsp_next.page_released = 1'b1;
                                    // push is dropped when the stack is full
                                    if (!stack_full)
                                    begin
                                        stk_we     = 1'b1;
                                        depth_next = depth_reg + DW'(1);
                                    end
                                end
                            end
                        end
                        rpa_pkg::CMD_INCR:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = rpa_pkg::STAT_RANGE;
                            end
                            else if (cnt_rd_data == rpa_pkg::CNT_MAX)
                            begin
                                rsp_next.status    = rpa_pkg::STAT_SATURATED;
                                rsp_next.ref_count = rpa_pkg::CNT_FIELD_W'(cnt_rd_data);
                            end
                            else
                            begin
                                cnt_we      = 1'b1;
                                cnt_wr_data = cnt_inc;
                                rsp_next.ref_count = rpa_pkg::CNT_FIELD_W'(cnt_inc);
                            end
                        end
                        default:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = rpa_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                rsp_next.ref_count = rpa_pkg::CNT_FIELD_W'(cnt_rd_data);
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        page_reg <= page_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

### tb/sv/page_pool_sb_pkg.sv
`timescale 1ns / 1ps

package page_pool_sb_pkg;

    class page_pool_scoreboard;

        // shadow registers
        logic [rpa_pkg::PG_FIELD_W-1:0]  first_pg;
        logic [rpa_pkg::END_W-1:0]       end_pg;

        // shadow of the block state
        logic [rpa_pkg::REF_WIDTH-1:0]   counts [rpa_pkg::NUM_PAGES];
        logic [rpa_pkg::PG_FIELD_W-1:0]  released [rpa_pkg::NUM_PAGES];
        int unsigned                     depth;
        int unsigned                     fresh_taken;

        rpa_pkg::rsp_t                   expected_q [$];
        int unsigned                     errors;
        int unsigned                     checked;
        int unsigned                     cmd_seen [4];

        function void clear_state();
            first_pg = '0;
            end_pg = '0;
            foreach (counts[i])
            begin
                counts[i] = '0;
                released[i] = '0;
            end
            depth = 0;
            fresh_taken = 0;
            errors = 0;
            checked = 0;
            foreach (cmd_seen[i])
                cmd_seen[i] = 0;
        endfunction

        function void set_first(logic [31:0] v);
            first_pg = v[rpa_pkg::PG_FIELD_W-1:0];
        endfunction

        function void set_end(logic [31:0] v);
            end_pg = v[rpa_pkg::END_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function rpa_pkg::rsp_t make_rsp(rpa_pkg::status_t st, int unsigned pg,
                                         int unsigned cnt, bit rel);
            rpa_pkg::rsp_t m;
            m.status = st;
            m.page_out = rpa_pkg::PG_FIELD_W'(pg);
            m.ref_count = rpa_pkg::CNT_FIELD_W'(cnt);
            m.page_released = rel;
            return m;
        endfunction

        // work out the response of one accepted request and update the shadow
        function void note_request(rpa_pkg::req_t r);
            int unsigned lim;
            int unsigned total;
            int unsigned np;
            int unsigned c;
            int unsigned pg;
            rpa_pkg::rsp_t e;
            lim = (end_pg > rpa_pkg::NUM_PAGES) ? rpa_pkg::NUM_PAGES : end_pg;
            pg = r.page_index;
            total = 0;
            cmd_seen[r.cmd]++;
            if (r.cmd == rpa_pkg::CMD_ALLOC)
            begin
                if (depth > 0)
                begin
                    depth--;
                    np = released[depth];
                end
                else
                begin
                    if (lim >= first_pg + 2)
                        total = lim - 1 - first_pg;
                    if (fresh_taken >= total)
                    begin
                        expected_q.push_back(make_rsp(rpa_pkg::STAT_EMPTY, 0, 0, 1'b0));
                        return;
                    end
                    np = lim - 2 - fresh_taken;
                    fresh_taken++;
                end
                if (np >= rpa_pkg::NUM_PAGES)
                    np = 0;
                counts[np] = 1;
                e = make_rsp(rpa_pkg::STAT_OK, np, 1, 1'b0);
            end
            else if (!(pg >= first_pg && pg < lim))
                e = make_rsp(rpa_pkg::STAT_RANGE, pg, 0, 1'b0);
            else
            begin
                c = counts[pg];
                case (r.cmd)
                    rpa_pkg::CMD_FREE:
                    begin
                        if (c == 0)
                            e = make_rsp(rpa_pkg::STAT_FREE_ZERO, pg, 0, 1'b0);
                        else
                        begin
                            c--;
                            counts[pg] = rpa_pkg::REF_WIDTH'(c);
                            if (c == 0)
                            begin
                                // push silently dropped once the stack is full
                                if (depth < rpa_pkg::NUM_PAGES)
                                begin
                                    released[depth] = rpa_pkg::PG_FIELD_W'(pg);
                                    depth++;
                                end
                                e = make_rsp(rpa_pkg::STAT_OK, pg, 0, 1'b1);
                            end
                            else
                                e = make_rsp(rpa_pkg::STAT_OK, pg, c, 1'b0);
                        end
                    end
                    rpa_pkg::CMD_INCR:
                    begin
                        if (c >= rpa_pkg::CNT_MAX)
                            e = make_rsp(rpa_pkg::STAT_SATURATED, pg, c, 1'b0);
                        else
                        begin
                            c++;
                            counts[pg] = rpa_pkg::REF_WIDTH'(c);
                            e = make_rsp(rpa_pkg::STAT_OK, pg, c, 1'b0);
                        end
                    end
                    default:
                        e = make_rsp(rpa_pkg::STAT_OK, pg, c, 1'b0);
                endcase
            end
            expected_q.push_back(e);
        endfunction

        function void check_response(rpa_pkg::rsp_t got);
            rpa_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                fail_note($sformatf({"mismatch: response with no request pending ",
                                     "(status %0d page %0d)"},
                                    got.status, got.page_out));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.status !== e.status || got.page_out !== e.page_out ||
                got.ref_count !== e.ref_count || got.page_released !== e.page_released)
                fail_note($sformatf({"mismatch on response %0d: expected status %0d page %0d ",
                                     "count %0d released %0b, got status %0d page %0d ",
                                     "count %0d released %0b"},
                                    checked, e.status, e.page_out, e.ref_count, e.page_released,
                                    got.status, got.page_out, got.ref_count, got.page_released));
        endfunction

    endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    // run limit, several times the slowest legal run including the clearing pass
    localparam int unsigned LIMIT_CYCLES = 1_500_000;

    // byte addresses of the two registers
    localparam logic [rpa_pkg::PADDR_W-1:0] ADDR_FIRST = {rpa_pkg::REG_FIRST, 2'b00};
    localparam logic [rpa_pkg::PADDR_W-1:0] ADDR_END   = {rpa_pkg::REG_END, 2'b00};

    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned PHASE_ITEMS   = 175;

    logic                 clk;
    logic                 rst_n = 1'b0;

    // request side
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    rpa_pkg::req_t        req = '0;

    // response side
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rpa_pkg::rsp_t        rsp;

    // apb side
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [rpa_pkg::PADDR_W-1:0]     paddr = '0;
    logic [rpa_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [rpa_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    page_pool_sb_pkg::page_pool_scoreboard  sb;

    // no new idling on either side while set
    bit                   calm = 1'b0;
    int unsigned          cycles = 0;
    int unsigned          region_writes = 0;

    // tb copy of the region, used to aim page numbers
    int unsigned          cur_first = 0;
    int unsigned          cur_end = 0;

    page_allocator_refcount dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // page number aimed mostly at the hot end of the region, where allocations land
    function automatic int unsigned pick_page();
        int unsigned r;
        int unsigned lim;
        int unsigned lo;
        lim = (cur_end > rpa_pkg::NUM_PAGES) ? rpa_pkg::NUM_PAGES : cur_end;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 32767);
        if (r < 30)
        begin
            case ($urandom_range(0, 5))
                0: return (cur_first - 1) & 32'h7fff;
                1: return cur_first & 32'h7fff;
                2: return (lim - 1) & 32'h7fff;
                3: return lim & 32'h7fff;
                4: return 0;
                default: return 32767;
            endcase
        end
        if (lim > cur_first)
        begin
            lo = (lim - cur_first > 64) ? lim - 64 : cur_first;
            return $urandom_range(lo, lim - 1);
        end
        return $urandom_range(0, 32767);
    endfunction

    // one request: hold it until accepted, then maybe idle
    task automatic send_cmd(input rpa_pkg::cmd_t c, input int unsigned pg);
        rpa_pkg::req_t r;
        int unsigned gap;
        r.cmd = c;
        r.page_index = rpa_pkg::PG_FIELD_W'(pg);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pauses until every expected response is back, then a short tail
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // setup and access phase, then an idle phase so transfers never share a step
    task automatic apb_access(input logic [rpa_pkg::PADDR_W-1:0] addr, input bit wr,
                              input logic [rpa_pkg::PDATA_W-1:0] wdata,
                              output logic [rpa_pkg::PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write both registers while idle, read them back
    task automatic set_region(input int unsigned first, input int unsigned last);
        logic [rpa_pkg::PDATA_W-1:0] rd;
        apb_access(ADDR_FIRST, 1'b1, rpa_pkg::PDATA_W'(first), rd);
        sb.set_first(rpa_pkg::PDATA_W'(first));
        apb_access(ADDR_END, 1'b1, rpa_pkg::PDATA_W'(last), rd);
        sb.set_end(rpa_pkg::PDATA_W'(last));
        apb_access(ADDR_FIRST, 1'b0, '0, rd);
        if (rd[rpa_pkg::PG_FIELD_W-1:0] !== rpa_pkg::PG_FIELD_W'(first))
            sb.fail_note($sformatf("mismatch: free_first_page reads %0h, wrote %0h",
                                   rd, first));
        apb_access(ADDR_END, 1'b0, '0, rd);
        if (rd[rpa_pkg::END_W-1:0] !== rpa_pkg::END_W'(last))
            sb.fail_note($sformatf("mismatch: free_end_page reads %0h, wrote %0h", rd, last));
        cur_first = first;
        cur_end = last;
        region_writes++;
    endtask

    // mostly well-formed traffic on the hot pages, some stray pages
    task automatic random_request();
        int unsigned r;
        rpa_pkg::cmd_t c;
        r = $urandom_range(0, 99);
        if (r < 30)
            c = rpa_pkg::CMD_ALLOC;
        else if (r < 55)
            c = rpa_pkg::CMD_FREE;
        else if (r < 80)
            c = rpa_pkg::CMD_INCR;
        else
            c = rpa_pkg::CMD_READ;
        send_cmd(c, pick_page());
    endtask

    // receiver stalls in bursts of random length
    initial
    begin : rsp_stall_gen
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_stall <= 1'b1;
            end
            else if (calm || $urandom_range(0, 99) < 70)
                rsp_stall <= 1'b0;
            else
            begin
                hold = pick_gap();
                rsp_stall <= 1'b1;
            end
        end
    end

    // response monitor, sampled at the edge that accepts
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // watchdog
    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d responses outstanding",
                 cycles, sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : main_seq
        int unsigned first;
        sb = new;
        sb.clear_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset region is empty: no pool, every page out of range
        set_region(0, 0);
        send_cmd(rpa_pkg::CMD_ALLOC, 32767);
        send_cmd(rpa_pkg::CMD_READ, 0);
        send_cmd(rpa_pkg::CMD_FREE, 32767);
        send_cmd(rpa_pkg::CMD_INCR, 0);
        drain();

        // top page only: it is in range but never handed out fresh
        set_region(32767, 32768);
        send_cmd(rpa_pkg::CMD_ALLOC, 0);
        send_cmd(rpa_pkg::CMD_INCR, 32767);
        send_cmd(rpa_pkg::CMD_READ, 32767);
        send_cmd(rpa_pkg::CMD_FREE, 32767);
        send_cmd(rpa_pkg::CMD_ALLOC, 12345);
        send_cmd(rpa_pkg::CMD_FREE, 32767);
        send_cmd(rpa_pkg::CMD_FREE, 32767);
        send_cmd(rpa_pkg::CMD_INCR, 32766);
        drain();

        // whole memory: pop the released page, then fresh pages from the top down
        set_region(0, 32768);
        send_cmd(rpa_pkg::CMD_ALLOC, 0);
        send_cmd(rpa_pkg::CMD_ALLOC, 0);
        send_cmd(rpa_pkg::CMD_ALLOC, 32767);
        send_cmd(rpa_pkg::CMD_INCR, 0);
        send_cmd(rpa_pkg::CMD_READ, 0);
        send_cmd(rpa_pkg::CMD_FREE, 0);
        send_cmd(rpa_pkg::CMD_FREE, 0);
        send_cmd(rpa_pkg::CMD_READ, 32766);

        // counter saturation on one page, then back down by one
        repeat (256) send_cmd(rpa_pkg::CMD_INCR, 100);
        send_cmd(rpa_pkg::CMD_READ, 100);
        send_cmd(rpa_pkg::CMD_FREE, 100);
        drain();

        // two-page region has one fresh page, already used up; then first past end
        set_region(0, 2);
        send_cmd(rpa_pkg::CMD_ALLOC, 0);
        drain();
        set_region(5, 3);
        send_cmd(rpa_pkg::CMD_READ, 4);
        drain();

        // random phases over several regions
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_region(40, 72);
                1: set_region(0, 32768);
                2: set_region(1000, 1003);
                3:
                begin
                    first = $urandom_range(0, 32700);
                    set_region(first, first + $urandom_range(2, 40));
                end
                default: set_region(20000, 10);
            endcase
            for (int unsigned i = 0; i < PHASE_ITEMS; i++)
            begin
                // quiet stretches now and then
                if (i % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                random_request();
                // occasional full pause until every response is back
                if ($urandom_range(0, 119) == 0)
                    drain();
            end
            calm = 1'b0;
            drain();
        end

        if (sb.pending() != 0)
            sb.fail_note($sformatf("mismatch: %0d responses never arrived", sb.pending()));
        $display("ran %0d requests: %0d allocate, %0d free, %0d increment, %0d read",
                 sb.cmd_seen[0] + sb.cmd_seen[1] + sb.cmd_seen[2] + sb.cmd_seen[3],
                 sb.cmd_seen[rpa_pkg::CMD_ALLOC], sb.cmd_seen[rpa_pkg::CMD_FREE],
                 sb.cmd_seen[rpa_pkg::CMD_INCR], sb.cmd_seen[rpa_pkg::CMD_READ]);
        $display("%0d responses over %0d region settings, incl. empty pool and saturation",
                 sb.checked, region_writes);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### page_allocator_refcount.f
src/rpa_pkg.sv
src/rpa_ram.sv
src/rpa_cfg.sv
src/page_allocator_refcount.sv
tb/sv/page_pool_sb_pkg.sv
tb/sv/tb.sv
